// ----- design/djdq_pkg.sv -----
// shared types and constants of the deadline job dispatch queue
package djdq_pkg;

  // field widths fixed by the interface
  localparam int unsigned ID_W   = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned OUTC_W = 2;
  localparam int unsigned LIMIT_W = 3;

  // queue limit after reset
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd3;

  // request kinds
  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_FLUSH   = 1'b1;

  // outcome codes of a result record
  localparam logic [OUTC_W-1:0] OUT_DONE    = 2'd0;
  localparam logic [OUTC_W-1:0] OUT_FULL    = 2'd1;
  localparam logic [OUTC_W-1:0] OUT_OVERRUN = 2'd2;
  localparam logic [OUTC_W-1:0] OUT_EXPIRED = 2'd3;

  // one waiting job as held in the queue memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] duration;
    logic [TIME_W-1:0] timeout;
  } job_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_DIRECT
  } state_t;

  // per-cycle control decisions of the sequencer
  typedef struct packed {
    logic push;       // move pending record into output register
    logic push_last;  // last flag of that record
    logic rd_en;      // read queue head
    logic wr_en;      // write arriving job at tail
    logic mk_full;    // build queue-full drop record
    logic run_head;   // evaluate queue head from memory data
    logic run_direct; // run the arriving job on an idle cpu
  } ctrl_t;

endpackage

// ----- design/djdq_ram.sv -----
// generic single-write, single-read ram with registered read data
module djdq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/deadline_job_dispatch_queue_unit.sv -----
// top level of the deadline job dispatch queue
// Single-server job dispatcher with a bounded queue of waiting jobs held in a
// synchronous ram of QUEUE_DEPTH entries. Each accepted request is either a
// job arrival or a flush; it produces zero or more result records, the final
// one marked by out_last. A request is taken only when the previous one has
// finished. Every waiting job dispatched takes a ram read of the queue head
// and then its evaluation, the loop of the sequencer; an arriving job that
// finds the cpu idle runs at once, and one that finds the queue full gets a
// drop record. The sequencer holds while an output record waits to be taken.
// The queue memory needs no clearing after reset: only counted slots are
// ever read.
// queue_limit is written through cfg_wr_en and cfg_wr_data; values above
// QUEUE_DEPTH act as QUEUE_DEPTH, zero drops every job that finds the cpu busy.
module deadline_job_dispatch_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration port
  input  logic                           cfg_wr_en,
  input  logic [djdq_pkg::LIMIT_W-1:0]   cfg_wr_data,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic [djdq_pkg::ID_W-1:0]      in_job_id,
  input  logic [djdq_pkg::TIME_W-1:0]    in_job_arrival,
  input  logic [djdq_pkg::TIME_W-1:0]    in_job_duration,
  input  logic [djdq_pkg::TIME_W-1:0]    in_job_timeout,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [djdq_pkg::ID_W-1:0]      out_result_id,
  output logic [djdq_pkg::OUTC_W-1:0]    out_outcome,
  output logic [djdq_pkg::TIME_W-1:0]    out_event_time,
  output logic [djdq_pkg::TIME_W-1:0]    out_delay,
  output logic                           out_last
);

  localparam int unsigned SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LIM_W  = (CNT_W > djdq_pkg::LIMIT_W) ? CNT_W : djdq_pkg::LIMIT_W;
  localparam int unsigned SUM_W  = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;
  localparam int unsigned T_W    = djdq_pkg::TIME_W;

  // state registers
  djdq_pkg::state_t               state_r, state_nxt;
  logic [T_W-1:0]                 cpu_time_r, cpu_time_nxt;
  logic [SLOT_W-1:0]              head_r, head_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [djdq_pkg::LIMIT_W-1:0]   limit_r;

  // latched request
  logic                           kind_r;
  djdq_pkg::job_t                 job_r;

  // pending record
  logic                           pend_r, pend_nxt;
  logic                           fin_r, fin_nxt;
  logic [djdq_pkg::ID_W-1:0]      rec_id_r, rec_id_nxt;
  logic [djdq_pkg::OUTC_W-1:0]    rec_outcome_r, rec_outcome_nxt;
  logic [T_W-1:0]                 rec_time_r, rec_time_nxt;
  logic [T_W-1:0]                 rec_delay_r, rec_delay_nxt;

  // output register
  logic                           out_valid_r;
  logic [djdq_pkg::ID_W-1:0]      out_id_r;
  logic [djdq_pkg::OUTC_W-1:0]    out_outcome_r;
  logic [T_W-1:0]                 out_time_r;
  logic [T_W-1:0]                 out_delay_r;
  logic                           out_last_r;

  djdq_pkg::ctrl_t                ctrl;
  djdq_pkg::job_t                 head_job;
  djdq_pkg::job_t                 in_job;
  logic                           in_acc;
  logic                           out_free;

  // decision terms
  logic                           cont;
  logic                           cpu_le_arr;
  logic                           is_full;
  logic [LIM_W-1:0]               lim_eff;
  logic [LIM_W-1:0]               count_ext;
  logic [LIM_W-1:0]               limit_ext;
  logic [SUM_W-1:0]               tail_sum;
  logic [SLOT_W-1:0]              tail_slot;

  // evaluation terms
  logic [T_W:0]                   head_end;
  logic                           head_expired;
  logic                           head_over;
  logic [T_W:0]                   direct_end;
  logic                           direct_over;

  assign in_ready = (state_r == djdq_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign in_job.id       = in_job_id;
  assign in_job.arrival  = in_job_arrival;
  assign in_job.duration = in_job_duration;
  assign in_job.timeout  = in_job_timeout;

  // queue memory
  djdq_ram #(
    .WIDTH ($bits(djdq_pkg::job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ctrl.wr_en),
    .waddr (tail_slot),
    .wdata (job_r),
    .re    (ctrl.rd_en),
    .raddr (head_r),
    .rdata (head_job)
  );

  // dispatch and admission conditions
  always_comb begin
    cpu_le_arr = (cpu_time_r <= job_r.arrival);
    cont       = (count_r != '0) && ((kind_r == djdq_pkg::KIND_FLUSH) || cpu_le_arr);
    count_ext  = LIM_W'(count_r);
    limit_ext  = LIM_W'(limit_r);
    lim_eff    = (limit_ext > LIM_W'(QUEUE_DEPTH)) ? LIM_W'(QUEUE_DEPTH) : limit_ext;
    is_full    = (count_ext >= lim_eff);
    tail_sum   = SUM_W'(head_r) + SUM_W'(count_r);
    tail_slot  = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                 SLOT_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : SLOT_W'(tail_sum);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      djdq_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = djdq_pkg::ST_CHECK;
        end
      end
      djdq_pkg::ST_CHECK: begin
        if (out_free) begin
          if (fin_r) begin
            state_nxt = djdq_pkg::ST_IDLE;
          end else if (cont) begin
            state_nxt = djdq_pkg::ST_RUN;
          end else if (kind_r == djdq_pkg::KIND_FLUSH) begin
            state_nxt = djdq_pkg::ST_IDLE;
          end else if (cpu_le_arr) begin
            state_nxt = djdq_pkg::ST_DIRECT;
          end else if (is_full) begin
            state_nxt = djdq_pkg::ST_CHECK;
          end else begin
            state_nxt = djdq_pkg::ST_IDLE;
          end
        end
      end
      djdq_pkg::ST_RUN:    state_nxt = djdq_pkg::ST_CHECK;
      djdq_pkg::ST_DIRECT: state_nxt = djdq_pkg::ST_CHECK;
      default:             state_nxt = djdq_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl = '0;
    case (state_r)
      djdq_pkg::ST_CHECK: begin
        if (out_free) begin
          ctrl.push = pend_r;
          if (fin_r) begin
            ctrl.push_last = 1'b1;
          end else if (cont) begin
            ctrl.rd_en = 1'b1;
          end else if (kind_r == djdq_pkg::KIND_FLUSH) begin
            ctrl.push_last = 1'b1;
          end else if (cpu_le_arr) begin
            ctrl.push_last = 1'b0;
          end else if (is_full) begin
            ctrl.mk_full = 1'b1;
          end else begin
            ctrl.push_last = 1'b1;
            ctrl.wr_en     = 1'b1;
          end
        end
      end
      djdq_pkg::ST_RUN:    ctrl.run_head   = 1'b1;
      djdq_pkg::ST_DIRECT: ctrl.run_direct = 1'b1;
      default:             ctrl = '0;
    endcase
  end

  // job evaluation: waiting head and direct run
  always_comb begin
    head_end     = {1'b0, cpu_time_r} + {1'b0, head_job.duration};
    head_expired = (cpu_time_r >= head_job.timeout);
    head_over    = (head_end > {1'b0, head_job.timeout});
    direct_end   = {1'b0, job_r.arrival} + {1'b0, job_r.duration};
    direct_over  = (direct_end > {1'b0, job_r.timeout});
  end

  // record, cpu time and queue bookkeeping
  always_comb begin
    cpu_time_nxt    = cpu_time_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    pend_nxt        = pend_r && !ctrl.push;
    fin_nxt         = fin_r;
    rec_id_nxt      = rec_id_r;
    rec_outcome_nxt = rec_outcome_r;
    rec_time_nxt    = rec_time_r;
    rec_delay_nxt   = rec_delay_r;
    if (state_r == djdq_pkg::ST_CHECK && out_free && fin_r) begin
      fin_nxt = 1'b0;
    end
    if (ctrl.wr_en) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (ctrl.mk_full) begin
      pend_nxt        = 1'b1;
      fin_nxt         = 1'b1;
      rec_id_nxt      = job_r.id;
      rec_outcome_nxt = djdq_pkg::OUT_FULL;
      rec_time_nxt    = job_r.arrival;
      rec_delay_nxt   = '0;
    end
    if (ctrl.run_head) begin
      pend_nxt   = 1'b1;
      rec_id_nxt = head_job.id;
      count_nxt  = count_r - CNT_W'(1);
      head_nxt   = (head_r == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + SLOT_W'(1);
      if (head_expired) begin
        rec_outcome_nxt = djdq_pkg::OUT_EXPIRED;
        rec_time_nxt    = cpu_time_r;
        rec_delay_nxt   = cpu_time_r - head_job.arrival;
      end else if (head_over) begin
        rec_outcome_nxt = djdq_pkg::OUT_OVERRUN;
        rec_time_nxt    = head_job.timeout;
        rec_delay_nxt   = head_job.timeout - head_job.arrival;
        cpu_time_nxt    = head_job.timeout;
      end else begin
        rec_outcome_nxt = djdq_pkg::OUT_DONE;
        rec_time_nxt    = head_end[T_W-1:0];
        rec_delay_nxt   = cpu_time_r - head_job.arrival;
        cpu_time_nxt    = head_end[T_W-1:0];
      end
    end
    if (ctrl.run_direct) begin
      pend_nxt   = 1'b1;
      fin_nxt    = 1'b1;
      rec_id_nxt = job_r.id;
      if (direct_over) begin
        rec_outcome_nxt = djdq_pkg::OUT_OVERRUN;
        rec_time_nxt    = job_r.timeout;
        rec_delay_nxt   = job_r.timeout - job_r.arrival;
        cpu_time_nxt    = job_r.timeout;
      end else begin
        rec_outcome_nxt = djdq_pkg::OUT_DONE;
        rec_time_nxt    = direct_end[T_W-1:0];
        rec_delay_nxt   = '0;
        cpu_time_nxt    = direct_end[T_W-1:0];
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= djdq_pkg::ST_IDLE;
      cpu_time_r  <= '0;
      head_r      <= '0;
      count_r     <= '0;
      limit_r     <= djdq_pkg::LIMIT_RESET;
      pend_r      <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cpu_time_r <= cpu_time_nxt;
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      pend_r     <= pend_nxt;
      fin_r      <= fin_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (ctrl.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_kind;
      job_r  <= in_job;
    end
    rec_id_r      <= rec_id_nxt;
    rec_outcome_r <= rec_outcome_nxt;
    rec_time_r    <= rec_time_nxt;
    rec_delay_r   <= rec_delay_nxt;
    if (ctrl.push) begin
      out_id_r      <= rec_id_r;
      out_outcome_r <= rec_outcome_r;
      out_time_r    <= rec_time_r;
      out_delay_r   <= rec_delay_r;
      out_last_r    <= ctrl.push_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_result_id  = out_id_r;
  assign out_outcome    = out_outcome_r;
  assign out_event_time = out_time_r;
  assign out_delay      = out_delay_r;
  assign out_last       = out_last_r;

  // queue never holds more jobs than it has slots
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("wait count exceeds queue depth");

  // a job is written only into a free slot
  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wr_en |-> (count_r < CNT_W'(QUEUE_DEPTH)))
    else $error("queue write with no free slot");

  // a head read only happens with a job waiting, and is evaluated next cycle
  a_read_then_run: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.rd_en |-> (count_r != '0) ##1 (state_r == djdq_pkg::ST_RUN))
    else $error("head read without waiting job or evaluation");

  // a new request is taken only with no record left pending
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!pend_r && !fin_r))
    else $error("request accepted while a record is pending");

endmodule

// ----- tb/deadline_job_dispatch_queue_unit_test.sv -----
// self-checking testbench of the deadline job dispatch queue unit
module deadline_job_dispatch_queue_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ID_W = djdq_pkg::ID_W;
  localparam int TIME_W = djdq_pkg::TIME_W;
  localparam int OUTC_W = djdq_pkg::OUTC_W;
  localparam int LIMIT_W = djdq_pkg::LIMIT_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int CYCLE_LIMIT = 300000;
  // drain margin: idle cycles after the last record of a phase
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_ITEMS = 40;
  localparam int NUM_PHASES = 7;

  // one request as the sender presents it
  typedef struct {
    logic              kind;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] duration;
    logic [TIME_W-1:0] timeout;
  } job_req_t;

  // one result record as the block should report it
  typedef struct {
    logic [ID_W-1:0]   id;
    logic [OUTC_W-1:0] outcome;
    logic [TIME_W-1:0] event_time;
    logic [TIME_W-1:0] delay;
    logic              last;
  } job_record_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [LIMIT_W-1:0] cfg_wr_data;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic [ID_W-1:0] in_job_id = '0;
  logic [TIME_W-1:0] in_job_arrival = '0;
  logic [TIME_W-1:0] in_job_duration = '0;
  logic [TIME_W-1:0] in_job_timeout = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ID_W-1:0] out_result_id;
  logic [OUTC_W-1:0] out_outcome;
  logic [TIME_W-1:0] out_event_time;
  logic [TIME_W-1:0] out_delay;
  logic out_last;

  // dispatcher model state
  logic [TIME_W-1:0] cpu_model = '0;
  djdq_pkg::job_t waiting_jobs [QUEUE_DEPTH];
  int head_model = 0;
  int count_model = 0;
  logic [LIMIT_W-1:0] limit_model = djdq_pkg::LIMIT_RESET;

  job_req_t request_backlog [$];
  job_record_t due_records [$];
  job_record_t record_batch [$];

  // handshake bookkeeping shared by driver and monitor
  bit req_taken = 1'b0;
  int req_gap = 0;
  int res_stall = 0;
  int in_gap_max = 8;
  int out_stall_max = 8;
  job_req_t drv_item;
  logic drv_valid_nx;

  logic [TIME_W-1:0] arr_clock = '0;
  int requests_sent = 0;
  int records_seen = 0;
  int mismatch_count = 0;
  int outcome_seen [4] = '{0, 0, 0, 0};
  int cycle_count = 0;
  int limit_plan [NUM_PHASES] = '{0, 1, 4, 7, 2, 5, 3};

  deadline_job_dispatch_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_job_id(in_job_id),
    .in_job_arrival(in_job_arrival),
    .in_job_duration(in_job_duration),
    .in_job_timeout(in_job_timeout),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_result_id(out_result_id),
    .out_outcome(out_outcome),
    .out_event_time(out_event_time),
    .out_delay(out_delay),
    .out_last(out_last)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run one job at the model cpu time and record its outcome
  function automatic void run_job_model(bit check_expiry, djdq_pkg::job_t j);
    logic [TIME_W:0] finish;
    job_record_t r;
    finish = {1'b0, cpu_model} + {1'b0, j.duration};
    r.id = j.id;
    r.last = 1'b0;
    if (check_expiry && cpu_model >= j.timeout) begin
      r.outcome = djdq_pkg::OUT_EXPIRED;
      r.event_time = cpu_model;
      r.delay = cpu_model - j.arrival;
    end else if (finish > {1'b0, j.timeout}) begin
      cpu_model = j.timeout;
      r.outcome = djdq_pkg::OUT_OVERRUN;
      r.event_time = j.timeout;
      r.delay = j.timeout - j.arrival;
    end else begin
      r.outcome = djdq_pkg::OUT_DONE;
      r.delay = cpu_model - j.arrival;
      cpu_model = finish[TIME_W-1:0];
      r.event_time = cpu_model;
    end
    record_batch = {record_batch, r};
  endfunction

  // take the queue head and run it
  function automatic void dispatch_head_model();
    djdq_pkg::job_t j;
    j = waiting_jobs[head_model];
    head_model = (head_model + 1) % QUEUE_DEPTH;
    count_model--;
    run_job_model(1'b1, j);
  endfunction

  // expected records of one accepted request
  function automatic void predict_dispatch(job_req_t q);
    int lim;
    djdq_pkg::job_t j;
    job_record_t r;
    record_batch.delete();
    j.id = q.id;
    j.arrival = q.arrival;
    j.duration = q.duration;
    j.timeout = q.timeout;
    if (q.kind == djdq_pkg::KIND_FLUSH) begin
      while (count_model > 0) dispatch_head_model();
    end else begin
      lim = (limit_model > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(limit_model);
      while (count_model > 0 && cpu_model <= q.arrival) dispatch_head_model();
      if (count_model == 0 && cpu_model <= q.arrival) begin
        cpu_model = q.arrival;
        run_job_model(1'b0, j);
      end else if (count_model >= lim) begin
        r.id = q.id;
        r.outcome = djdq_pkg::OUT_FULL;
        r.event_time = q.arrival;
        r.delay = '0;
        r.last = 1'b0;
        record_batch = {record_batch, r};
      end else begin
        waiting_jobs[(head_model + count_model) % QUEUE_DEPTH] = j;
        count_model++;
      end
    end
    if (record_batch.size() > 0) record_batch[record_batch.size()-1].last = 1'b1;
    due_records = {due_records, record_batch};
  endfunction

  function automatic void compare_field(string name, logic [TIME_W-1:0] want,
                                        logic [TIME_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // monitor: configuration writes, accepted requests and accepted records
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (cfg_wr_en) limit_model = cfg_wr_data;
      if (out_valid && out_ready) begin
        records_seen++;
        outcome_seen[out_outcome]++;
        if (due_records.size() == 0) begin
          $error("result record id %0h with no request awaiting it", out_result_id);
          mismatch_count++;
        end else begin
          compare_field("result_id", TIME_W'(due_records[0].id), TIME_W'(out_result_id));
          compare_field("outcome", TIME_W'(due_records[0].outcome), TIME_W'(out_outcome));
          compare_field("event_time", due_records[0].event_time, out_event_time);
          compare_field("delay", due_records[0].delay, out_delay);
          compare_field("last", TIME_W'(due_records[0].last), TIME_W'(out_last));
          void'(due_records.pop_front());
        end
        res_stall = $urandom_range(0, out_stall_max);
      end
      if (in_valid && in_ready) begin
        predict_dispatch('{in_kind, in_job_id, in_job_arrival, in_job_duration,
                           in_job_timeout});
        requests_sent++;
        req_taken = 1'b1;
        req_gap = $urandom_range(0, in_gap_max);
      end
    end
  end

  // driver: presents backlog requests and paces out_ready
  always @(negedge clk) begin
    if (rst_n === 1'b1) begin
      drv_valid_nx = in_valid;
      if (req_taken) begin
        drv_valid_nx = 1'b0;
        req_taken = 1'b0;
      end
      if (!drv_valid_nx) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (request_backlog.size() > 0) begin
          drv_item = request_backlog.pop_front();
          in_kind <= drv_item.kind;
          in_job_id <= drv_item.id;
          in_job_arrival <= drv_item.arrival;
          in_job_duration <= drv_item.duration;
          in_job_timeout <= drv_item.timeout;
          drv_valid_nx = 1'b1;
        end
      end
      in_valid <= drv_valid_nx;
      if (res_stall > 0) begin
        out_ready <= 1'b0;
        res_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout with %0d records outstanding", due_records.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic add_job(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] arr,
                         input logic [TIME_W-1:0] dur, input logic [TIME_W-1:0] tmo);
    request_backlog = {request_backlog,
                       job_req_t'{djdq_pkg::KIND_ARRIVAL, id, arr, dur, tmo}};
  endtask

  task automatic add_flush();
    request_backlog = {request_backlog,
                       job_req_t'{djdq_pkg::KIND_FLUSH, ID_W'($urandom), $urandom,
                                  $urandom, $urandom}};
  endtask

  // random requests: mostly in-order arrivals, some out of order, a few flushes
  task automatic gen_phase(input int count);
    job_req_t r;
    int sel;
    int tsel;
    int dsel;
    for (int i = 0; i < count; i++) begin
      r.kind = djdq_pkg::KIND_ARRIVAL;
      r.id = ID_W'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
        r.kind = djdq_pkg::KIND_FLUSH;
        r.arrival = $urandom;
        r.duration = $urandom;
        r.timeout = $urandom;
      end else begin
        if (sel < 74) arr_clock += $urandom_range(0, 15);
        else if (sel < 91) arr_clock += $urandom_range(40, 400);
        r.arrival = (sel >= 91) ? arr_clock - $urandom_range(1, 300) : arr_clock;
        tsel = $urandom_range(0, 99);
        if (tsel < 50) r.timeout = r.arrival + $urandom_range(0, 200);
        else if (tsel < 65) r.timeout = r.arrival + $urandom_range(0, 20);
        else if (tsel < 75) r.timeout = r.arrival;
        else if (tsel < 85) r.timeout = '1;
        else r.timeout = $urandom;
        // huge durations only with a near timeout, so the cpu never runs far ahead
        dsel = $urandom_range(0, 99);
        if (dsel < 15) r.duration = '0;
        else if (dsel < 30 && tsel < 75) r.duration = $urandom;
        else if (dsel < 40) r.duration = $urandom_range(60, 200);
        else r.duration = $urandom_range(0, 60);
      end
      request_backlog = {request_backlog, r};
    end
  endtask

  // wait until every request is in and every record is out, then settle
  task automatic wait_quiet();
    while (request_backlog.size() > 0 || in_valid || due_records.size() > 0) begin
      @(negedge clk);
      #1;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // stimulus sequence
  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    #1;

    // directed part at the reset limit of three
    add_job(16'h0001, 32'd0, 32'd0, 32'd0);
    add_flush();
    add_job(16'h0002, 32'd10, 32'd100, 32'd1000);
    add_job(16'h0003, 32'd20, 32'd5, 32'd30);
    add_job(16'h0004, 32'd30, 32'd50, 32'd1000);
    add_job(16'h0005, 32'd40, 32'd1, 32'd1000);
    add_job(16'h0006, 32'd50, 32'd7, 32'd1000);
    add_job(16'h0007, 32'd200, 32'd10, 32'd300);
    add_job(16'h0008, 32'd300, 32'd100, 32'd350);
    add_job(16'h0009, 32'd340, 32'd100, 32'd400);
    add_flush();
    // finish exactly on the timeout, then expiry exactly on the timeout
    add_job(16'h000a, 32'd500, 32'd50, 32'd550);
    add_job(16'h000b, 32'd560, 32'd40, 32'd1000);
    add_job(16'h000c, 32'd570, 32'd1, 32'd600);
    add_flush();
    wait_quiet();

    // random phases, one queue limit each
    for (int p = 0; p < NUM_PHASES; p++) begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= LIMIT_W'(limit_plan[p]);
      @(negedge clk);
      cfg_wr_en <= 1'b0;
      #1;
      in_gap_max = (p % 3 == 0) ? 0 : 8;
      out_stall_max = (p % 3 == 0) ? 0 : 8;
      arr_clock = (p + 1) * 32'h2000_0000 + $urandom_range(0, 32'h0FFF_FFFF);
      gen_phase(PHASE_ITEMS);
      wait_quiet();
    end

    // extreme times and ids, wrap of the time base
    in_gap_max = 8;
    out_stall_max = 8;
    add_flush();
    add_job(16'hffff, 32'hffff_fff0, 32'hffff_ffff, 32'hffff_ffff);
    add_job(16'h0000, 32'd5, 32'd0, 32'hffff_ffff);
    add_job(16'h0001, 32'hffff_ffff, 32'd0, 32'hffff_ffff);
    add_job(16'hffff, 32'd0, 32'hffff_ffff, 32'd0);
    add_flush();
    wait_quiet();

    $display("%0d requests over queue limits 3,0,1,4,7,2,5,3; %0d records checked",
             requests_sent, records_seen);
    $display("outcomes: done %0d, dropped %0d, overrun %0d, expired %0d; %0d mismatches",
             outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- deadline_job_dispatch_queue_unit.f -----
design/djdq_pkg.sv
design/djdq_ram.sv
design/deadline_job_dispatch_queue_unit.sv
tb/deadline_job_dispatch_queue_unit_test.sv
